[design/sta_pkg.sv]
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types, field widths and scancode set 1 translation tables for the
// scancode to ascii fifo block.
// ----------------------------------------------------------------------------
package sta_pkg;

    localparam int SC_W     = 8;
    localparam int CHAR_W   = 7;
    localparam int TAB_LEN  = 60;
    localparam int TAB_IDX_W = 6;

    // scancodes with a meaning of their own
    localparam logic [SC_W-1:0] SC_LSHIFT  = 8'h2A;
    localparam logic [SC_W-1:0] SC_RSHIFT  = 8'h36;
    localparam logic [SC_W-1:0] SC_RELEASE = 8'h80;
    localparam logic [SC_W-1:0] SC_LSHIFT_UP = SC_LSHIFT | SC_RELEASE;
    localparam logic [SC_W-1:0] SC_RSHIFT_UP = SC_RSHIFT | SC_RELEASE;
    localparam logic [SC_W-1:0] SC_TAB_END = 8'd60;

    // request codes
    localparam logic CMD_SCANCODE = 1'b0;
    localparam logic CMD_READ     = 1'b1;

    // unshifted key table
    localparam logic [CHAR_W-1:0] PLAIN_TAB [TAB_LEN] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
        7'h6a, 7'h6b, 7'h6c, 7'h3b, 7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00
    };

    // shifted key table
    localparam logic [CHAR_W-1:0] UPPER_TAB [TAB_LEN] = '{
        7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a, 7'h28, 7'h29,
        7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
        7'h4a, 7'h4b, 7'h4c, 7'h3a, 7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00
    };

    // translated character headed for the fifo
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;
    } sta_push_t;

endpackage

[design/sta_if.sv]
// ----------------------------------------------------------------------------
// sta_if
// Valid/ready channels of the scancode to ascii fifo block: the request
// channel (scancode byte or read) and the response channel (character).
// ----------------------------------------------------------------------------
interface sta_req_if;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [sta_pkg::SC_W-1:0] scancode;

    modport source (output valid, output cmd, output scancode, input ready);
    modport sink   (input valid, input cmd, input scancode, output ready);
endinterface

interface sta_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [sta_pkg::CHAR_W-1:0] char_code;
    logic                       was_empty;

    modport source (output valid, output char_code, output was_empty, input ready);
    modport sink   (input valid, input char_code, input was_empty, output ready);
endinterface

[design/scancode_to_ascii_fifo_top.sv]
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_top
// Keyboard scancode (set 1) to ascii translation with a ring fifo of
// characters, drained by read requests.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per scancode byte (cmd = scancode) or per read
//   request (cmd = read). Only a read produces a beat on rsp: the oldest
//   character, or char_code = 0 with was_empty = 1 when nothing is stored.
//   Characters live in a single-port-write, registered-read memory of
//   FIFO_DEPTH entries holding at most FIFO_DEPTH-1 characters; a character
//   that finds the fifo full is dropped.
// Sequence:
//   scancode beats are taken back to back while no read is pending. A read
//   beat first reads the memory into a data register while the read is
//   pending, then loads the output register, where rsp.valid rises; req.ready
//   drops while the read is pending, so a new read is taken only once the previous one has reached the output register.
// Stalls:
//   the response waits in an output register; scancode beats are still taken
//   while it waits, a further read waits until the response is taken.
// Reset:
//   clears shift state, both pointers and the response valid; the character
//   memory is not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_top #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    sta_req_if.sink          req,
    sta_rsp_if.source        rsp
);
    import sta_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);

    logic [CHAR_W-1:0] mem [FIFO_DEPTH];

    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_inc;
    logic [PTR_W-1:0]  rd_ptr_inc;
    logic [CHAR_W-1:0] rd_data_reg;
    logic              pend_reg;
    logic              pend_empty_reg;
    logic              rsp_valid_reg;
    logic [CHAR_W-1:0] rsp_char_reg;
    logic              rsp_empty_reg;

    logic              req_beat;
    logic              sc_beat;
    logic              rd_beat;
    logic              fifo_empty;
    logic              wr_en;
    sta_push_t         push;

    // request handshake
    assign req.ready = !pend_reg && (req.cmd == CMD_SCANCODE || !rsp_valid_reg || rsp.ready);
    assign req_beat  = req.valid && req.ready;
    assign sc_beat   = req_beat && (req.cmd == CMD_SCANCODE);
    assign rd_beat   = req_beat && (req.cmd == CMD_READ);

    sta_keymap u_keymap (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (sc_beat),
        .scancode (req.scancode),
        .push     (push)
    );

    // ring pointers
    assign wr_ptr_inc = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
    assign fifo_empty = (wr_ptr_reg == rd_ptr_reg);
    assign wr_en      = push.valid && (wr_ptr_inc != rd_ptr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_inc;
            end
            if (rd_beat && !fifo_empty)
            begin
                rd_ptr_reg <= rd_ptr_inc;
            end
        end
    end

    // character memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= push.ch;
        end
        if (rd_beat)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // read in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= rd_beat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_beat)
        begin
            pend_empty_reg <= fifo_empty;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (pend_reg)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            rsp_char_reg  <= pend_empty_reg ? '0 : rd_data_reg;
            rsp_empty_reg <= pend_empty_reg;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.char_code = rsp_char_reg;
    assign rsp.was_empty = rsp_empty_reg;

    // a read in flight always lands in the response register
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg |=> rsp_valid_reg)
        else $error("read in flight did not reach the response register");

    // a read beat is followed by a pending memory read
    assert property (@(posedge clk) disable iff (!rst_n) rd_beat |=> pend_reg)
        else $error("read beat without a pending memory read");

    // no new request while a read is in flight
    assert property (@(posedge clk) disable iff (!rst_n) pend_reg |-> !req.ready)
        else $error("request taken during a pending read");

    // a pending read never overwrites a response still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (!rsp_valid_reg || $past(rsp.ready)))
        else $error("response overwritten before it was taken");

    // a write never makes the fifo look empty
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |=> !fifo_empty)
        else $error("fifo write wrapped onto the read pointer");

endmodule

[design/sta_keymap.sv]
// ----------------------------------------------------------------------------
// sta_keymap
// Tracks the shift keys and translates press codes through the unshifted or
// shifted key table; flags a character to be pushed into the fifo.
// ----------------------------------------------------------------------------
module sta_keymap (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  logic [sta_pkg::SC_W-1:0] scancode,
    output sta_pkg::sta_push_t       push
);
    import sta_pkg::*;

    logic                 shift_held_reg;
    logic                 shift_held_next;
    logic                 in_table;
    logic [TAB_IDX_W-1:0] idx;
    logic [CHAR_W-1:0]    plain_ch;
    logic [CHAR_W-1:0]    upper_ch;

    // table lookup; index only meaningful for codes below the table end
    assign in_table = !scancode[SC_W-1] && (scancode < SC_TAB_END);
    assign idx      = in_table ? scancode[TAB_IDX_W-1:0] : '0;
    assign plain_ch = PLAIN_TAB[idx];
    assign upper_ch = UPPER_TAB[idx];

    // shift press and release
    always_comb
    begin
        shift_held_next = shift_held_reg;
        if (take && (scancode == SC_LSHIFT || scancode == SC_RSHIFT))
        begin
            shift_held_next = 1'b1;
        end
        else if (take && (scancode == SC_LSHIFT_UP || scancode == SC_RSHIFT_UP))
        begin
            shift_held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_held_reg <= 1'b0;
        end
        else
        begin
            shift_held_reg <= shift_held_next;
        end
    end

    // shift codes fall inside the table but map to zero, so they never push
    assign push.valid = take && in_table && (plain_ch != '0);
    assign push.ch    = shift_held_reg ? upper_ch : plain_ch;

endmodule

[verif/scancode_to_ascii_fifo_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_top_tb
// Drives scancode bytes and read requests into the block and checks every
// character beat against a cycle-free model of the shift flag, the key tables
// and the ring fifo, or a typed row of the short directed table, which comes
// first; then noise, key typing, a fill-to-overflow pass, a drain and typing.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_top_tb;
    import sta_pkg::*;

    localparam int FIFO_DEPTH = 256;
    localparam logic [SC_W-1:0] SC_PREFIX_EXT = 8'hE0;

    // key tables, scancode set 1
    localparam logic [CHAR_W-1:0] KEY_PLAIN [TAB_LEN] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
        7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
        7'h6a, 7'h6b, 7'h6c, 7'h3b, 7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00
    };
    localparam logic [CHAR_W-1:0] KEY_SHIFTED [TAB_LEN] = '{
        7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a, 7'h28, 7'h29,
        7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
        7'h4a, 7'h4b, 7'h4c, 7'h3a, 7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20, 7'h00, 7'h00
    };

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              was_empty;
    } char_rsp_t;

    typedef struct {
        logic            cmd;
        logic [SC_W-1:0] sc;
        bit              typed;
        char_rsp_t       rsp;
    } dir_row_t;

    logic clk;
    logic rst_n;

    sta_req_if req_ch ();
    sta_rsp_if rsp_ch ();

    scancode_to_ascii_fifo_top #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // model state
    bit                shift_on;
    logic [CHAR_W-1:0] char_mem [FIFO_DEPTH];
    int unsigned       wr_idx;
    int unsigned       rd_idx;

    char_rsp_t char_q [$];
    int        err_cnt;
    int        beats_sent;
    bit        idle_on;
    int        stall_left = 0;

    // directed beats: reset state, ignored codes, both shifts, drain to empty
    dir_row_t dir_tab [25] = '{
        '{CMD_READ,     8'h00,        1'b1, '{7'h00, 1'b1}},
        '{CMD_SCANCODE, 8'h00,        1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, 8'hFF,        1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, SC_PREFIX_EXT, 1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, SC_TAB_END,   1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, 8'h3B,        1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, 8'h01,        1'b0, '{7'h00, 1'b0}},
        '{CMD_READ,     8'hFF,        1'b1, '{7'h00, 1'b1}},
        '{CMD_SCANCODE, 8'h02,        1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, 8'h82,        1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, SC_LSHIFT,    1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, 8'h02,        1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, 8'h01,        1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, SC_LSHIFT_UP, 1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, SC_RSHIFT,    1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, 8'h39,        1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, 8'h35,        1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, SC_RSHIFT_UP, 1'b0, '{7'h00, 1'b0}},
        '{CMD_SCANCODE, 8'h35,        1'b0, '{7'h00, 1'b0}},
        '{CMD_READ,     8'h00,        1'b0, '{7'h00, 1'b0}},
        '{CMD_READ,     8'h55,        1'b0, '{7'h00, 1'b0}},
        '{CMD_READ,     8'hAA,        1'b0, '{7'h00, 1'b0}},
        '{CMD_READ,     8'h00,        1'b0, '{7'h00, 1'b0}},
        '{CMD_READ,     8'h00,        1'b0, '{7'h00, 1'b0}},
        '{CMD_READ,     8'h00,        1'b1, '{7'h00, 1'b1}}
    };

    // translate one request and return 1 when it yields a character beat
    function automatic bit key_fifo_step(input logic cmd, input logic [SC_W-1:0] sc,
                                         output char_rsp_t r);
        int unsigned nxt;
        r = '0;
        if (cmd == CMD_SCANCODE)
        begin
            if (sc == SC_LSHIFT || sc == SC_RSHIFT)
                shift_on = 1'b1;
            else if (sc == SC_LSHIFT_UP || sc == SC_RSHIFT_UP)
                shift_on = 1'b0;
            else if (!sc[7] && sc < SC_TAB_END && KEY_PLAIN[sc[TAB_IDX_W-1:0]] != '0)
            begin
                nxt = (wr_idx + 1) % FIFO_DEPTH;
                if (nxt != rd_idx)
                begin
                    char_mem[wr_idx] = shift_on ? KEY_SHIFTED[sc[TAB_IDX_W-1:0]]
                                                : KEY_PLAIN[sc[TAB_IDX_W-1:0]];
                    wr_idx = nxt;
                end
            end
            return 1'b0;
        end
        if (wr_idx == rd_idx)
        begin
            r.char_code = '0;
            r.was_empty = 1'b1;
        end
        else
        begin
            r.char_code = char_mem[rd_idx];
            r.was_empty = 1'b0;
            rd_idx = (rd_idx + 1) % FIFO_DEPTH;
        end
        return 1'b1;
    endfunction

    function automatic logic [SC_W-1:0] pick_key();
        logic [SC_W-1:0] k;
        do
            k = SC_W'($urandom_range(1, TAB_LEN - 1));
        while (KEY_PLAIN[k[TAB_IDX_W-1:0]] == '0);
        return k;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // one request beat, optionally after an idle burst
    task automatic send_beat(input logic cmd, input logic [SC_W-1:0] sc,
                             input bit typed, input char_rsp_t typed_rsp);
        int        gap;
        bit        has;
        char_rsp_t r;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= cmd;
        req_ch.scancode <= sc;
        do
            @(posedge clk);
        while (!req_ch.ready);
        has = key_fifo_step(cmd, sc, r);
        if (has)
            char_q.push_back(typed ? typed_rsp : r);
        beats_sent++;
    endtask

    task automatic send_sc(input logic [SC_W-1:0] sc);
        send_beat(CMD_SCANCODE, sc, 1'b0, '0);
    endtask

    task automatic send_read();
        send_beat(CMD_READ, SC_W'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // press and release of one key, sometimes with a shift around it
    task automatic type_key();
        logic [SC_W-1:0] k;
        logic [SC_W-1:0] sh;
        bit              shifted;
        k       = pick_key();
        shifted = ($urandom_range(0, 2) == 0);
        sh      = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
        if (shifted)
            send_sc(sh);
        send_sc(k);
        if ($urandom_range(0, 3) == 0)
            send_sc(k);
        send_sc(k | SC_RELEASE);
        if (shifted && $urandom_range(0, 9) != 0)
        begin
            if ($urandom_range(0, 7) == 0)
                sh = (sh == SC_LSHIFT) ? SC_RSHIFT : SC_LSHIFT;
            send_sc(sh | SC_RELEASE);
        end
    endtask

    // typing mixed with reads and a little noise
    task automatic typing_session(input int until_beats);
        int r;
        while (beats_sent < until_beats)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                type_key();
            else if (r < 8)
                send_read();
            else if (r == 8)
            begin
                send_sc(SC_PREFIX_EXT);
                send_sc(SC_W'($urandom_range(0, 255)));
            end
            else
                send_sc(SC_W'($urandom_range(0, 255)));
        end
    endtask

    // response side stalls in random bursts while idling is enabled
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // check each character beat against the oldest expected one
    always @(posedge clk)
    begin
        char_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (char_q.size() == 0)
            begin
                $error("unexpected beat: char_code %0h was_empty %0b",
                       rsp_ch.char_code, rsp_ch.was_empty);
                err_cnt++;
            end
            else
            begin
                want = char_q.pop_front();
                if (rsp_ch.char_code !== want.char_code)
                begin
                    $error("char_code: expected %0h actual %0h",
                           want.char_code, rsp_ch.char_code);
                    err_cnt++;
                end
                if (rsp_ch.was_empty !== want.was_empty)
                begin
                    $error("was_empty: expected %0b actual %0b",
                           want.was_empty, rsp_ch.was_empty);
                    err_cnt++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        int wait_cnt;
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = CMD_SCANCODE;
        req_ch.scancode = '0;
        shift_on        = 1'b0;
        wr_idx          = 0;
        rd_idx          = 0;
        err_cnt         = 0;
        beats_sent      = 0;
        idle_on         = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_tab[i])
            send_beat(dir_tab[i].cmd, dir_tab[i].sc, dir_tab[i].typed, dir_tab[i].rsp);

        // noise over the whole input space
        while (beats_sent < 325)
        begin
            if ($urandom_range(0, 2) == 0)
                send_read();
            else
                send_sc(SC_W'($urandom_range(0, 255)));
        end

        typing_session(1025);

        // fill past capacity, then drain past empty
        repeat (270)
        begin
            if ($urandom_range(0, 5) == 0)
                send_sc($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT);
            else if ($urandom_range(0, 5) == 0)
                send_sc($urandom_range(0, 1) ? SC_LSHIFT_UP : SC_RSHIFT_UP);
            send_sc(pick_key());
        end
        repeat (270) send_read();

        // last stretch with no idling on either side
        idle_on = 1'b0;
        typing_session(beats_sent + 300);

        @(negedge clk);
        req_ch.valid <= 1'b0;

        wait_cnt = 0;
        while (char_q.size() != 0 && wait_cnt < 1000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (10) @(posedge clk);
        if (err_cnt == 0 && char_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/sta_pkg.sv
design/sta_if.sv
design/sta_keymap.sv
design/scancode_to_ascii_fifo_top.sv
verif/scancode_to_ascii_fifo_top_tb.sv
